// ===== hw/rtl/rtae_pkg.sv =====
// ============================================================================
// rtae_pkg
// Shared constants, codes and types for the route table aging engine.
// ============================================================================
package rtae_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 32;
    localparam int HOP_ADDR_BITS = 48;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ISSUE_W       = $clog2(TABLE_ENTRIES + 1);

    // Field widths fixed by the channel format
    localparam int FUNC_W    = 2;
    localparam int KEY_W     = 32;
    localparam int NH_W      = 48;
    localparam int HOPS_W    = 8;
    localparam int SEQ_W     = 16;
    localparam int TIME_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 6;
    localparam int TIMEOUT_W = 16;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_TIMEOUT = 1'b0;   // register index, from paddr[2]
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd20;

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_AGE    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REPLACED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_KEPT      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_AGED      = 3'd6;

    // One stored route (key lives in the match unit)
    typedef struct packed {
        logic [HOP_ADDR_BITS-1:0] link_addr;
        logic [HOPS_W-1:0]        hops;
        logic [SEQ_W-1:0]         seq;
        logic [TIME_W-1:0]        stamp;
    } entry_t;

    // Commands into the key match unit
    typedef struct packed {
        logic             cmp;    // register match and free vectors
        logic             wr;     // write key, set valid
        logic             clr;    // clear valid
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
    } km_cmd_t;

    // Search results out of the key match unit
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             has_free;
        logic [IDX_W-1:0] free_idx;
    } km_stat_t;

endpackage

// ===== hw/rtl/rtae_if.sv =====
// ============================================================================
// rtae_if
// Valid/ready channels: request beats in, result beats out.
// ============================================================================
interface rtae_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] dest_id;
    logic [47:0] next_hop_addr;
    logic [7:0]  hops;
    logic [15:0] seq;
    logic [31:0] now;

    modport source (
        output valid, func, dest_id, next_hop_addr, hops, seq, now,
        input  ready
    );
    modport sink (
        input  valid, func, dest_id, next_hop_addr, hops, seq, now,
        output ready
    );
endinterface

interface rtae_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [47:0] route_next_hop;
    logic [7:0]  route_hops;
    logic [15:0] route_seq;
    logic [5:0]  removed_count;

    modport source (
        output valid, status, route_next_hop, route_hops, route_seq, removed_count,
        input  ready
    );
    modport sink (
        input  valid, status, route_next_hop, route_hops, route_seq, removed_count,
        output ready
    );
endinterface

// ===== hw/rtl/route_table_aging_engine_top.sv =====
// ============================================================================
// route_table_aging_engine_top
// Routing table with update, lookup and aging over a payload memory.
// ============================================================================
//
//  channel   dir  beat contents
//  --------  ---  ----------------------------------------------------------
//  in_ch     in   func, dest_id, next_hop_addr, hops, seq, now
//  out_ch    out  status, route_next_hop, route_hops, route_seq, removed_count
//  apb       in   timeout_seconds at byte address 0
//
//  Update and lookup go through key compare at accept, priority
//  encode and memory read, then decide and write back. Aging makes
//  one memory read per entry. Code 3 is accepted with no result.
//  Reset empties the table at once through the valid flops.
//  A result waits in the output register; the next request is accepted
//  meanwhile, and a finished request holds in its last state while the
//  output register is full. Reads and writes of the memory never share
//  a cycle, so no forwarding is needed.
//
module route_table_aging_engine_top (
    input  logic                         clk,
    input  logic                         rst_n,
    rtae_in_if.sink                      in_ch,
    rtae_out_if.source                   out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rtae_pkg::PADDR_W-1:0] paddr,
    input  logic [rtae_pkg::PDATA_W-1:0] pwdata,
    output logic [rtae_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import rtae_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FIND = 4'b0010,
        S_READ = 4'b0100,
        S_AGE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // latched request
    logic [FUNC_W-1:0]  func_reg, func_next;
    logic [KEY_W-1:0]   dest_reg, dest_next;
    logic [NH_W-1:0]    nh_reg, nh_next;
    logic [HOPS_W-1:0]  hops_reg, hops_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;
    logic [TIME_W-1:0]  now_reg, now_next;

    // aging sweep
    logic [ISSUE_W-1:0] issue_reg, issue_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [COUNT_W-1:0] removed_reg, removed_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [NH_W-1:0]     out_nh_reg, out_nh_next;
    logic [HOPS_W-1:0]   out_hops_reg, out_hops_next;
    logic [SEQ_W-1:0]    out_seq_reg, out_seq_next;
    logic [COUNT_W-1:0]  out_cnt_reg, out_cnt_next;

    logic                     accept;
    logic                     out_free;
    logic [TIMEOUT_W-1:0]     timeout;
    km_cmd_t                  km_cmd;
    km_stat_t                 km_stat;
    logic [TABLE_ENTRIES-1:0] valid;
    logic                     ram_wr_en;
    logic [IDX_W-1:0]         ram_wr_addr;
    entry_t                   ram_wr_data;
    logic                     ram_rd_en;
    logic [IDX_W-1:0]         ram_rd_addr;
    entry_t                   ram_rd_data;
    logic                     stale;
    logic                     sweep_done;

    rtae_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .timeout (timeout)
    );

    rtae_key_match u_key_match (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (km_cmd),
        .stat  (km_stat),
        .valid (valid)
    );

    rtae_entry_ram u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    // entry expires when stamp + timeout < now, formed in 33 bits
    assign stale = ({1'b0, ram_rd_data.stamp} + (TIME_W + 1)'(timeout))
                   < {1'b0, now_reg};
    assign sweep_done = (issue_reg == ISSUE_W'(TABLE_ENTRIES)) && !pend_reg;

    // control sequencer
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        dest_next      = dest_reg;
        nh_next        = nh_reg;
        hops_next      = hops_reg;
        seq_next       = seq_reg;
        now_next       = now_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        removed_next   = removed_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_status_next = out_status_reg;
        out_nh_next    = out_nh_reg;
        out_hops_next  = out_hops_reg;
        out_seq_next   = out_seq_reg;
        out_cnt_next   = out_cnt_reg;
        km_cmd         = '0;
        km_cmd.key     = dest_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = km_stat.hit_idx;
        ram_wr_data.link_addr = HOP_ADDR_BITS'(nh_reg);
        ram_wr_data.hops      = hops_reg;
        ram_wr_data.seq       = seq_reg;
        ram_wr_data.stamp     = now_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = km_stat.hit_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next  = in_ch.func;
                    dest_next  = in_ch.dest_id;
                    nh_next    = in_ch.next_hop_addr;
                    hops_next  = in_ch.hops;
                    seq_next   = in_ch.seq;
                    now_next   = in_ch.now;
                    km_cmd.cmp = 1'b1;
                    km_cmd.key = in_ch.dest_id;
                    priority if (in_ch.func == FUNC_AGE)
                    begin
                        issue_next   = '0;
                        removed_next = '0;
                        state_next   = S_AGE;
                    end
                    else if (in_ch.func == FUNC_NONE)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_FIND;
                    end
                end
            end

            // match vectors ready: fetch the hit entry
            S_FIND:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_READ;
            end

            // decide, write back if needed and post the result when the output is free
            S_READ:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_nh_next     = '0;
                    out_hops_next   = '0;
                    out_seq_next    = '0;
                    out_cnt_next    = '0;
                    state_next      = S_IDLE;
                    priority if (func_reg == FUNC_LOOKUP)
                    begin
                        if (km_stat.hit)
                        begin
                            out_status_next = ST_FOUND;
                            out_nh_next     = NH_W'(ram_rd_data.link_addr);
                            out_hops_next   = ram_rd_data.hops;
                            out_seq_next    = ram_rd_data.seq;
                        end
                        else
                        begin
                            out_status_next = ST_NOT_FOUND;
                        end
                    end
                    else if (km_stat.hit)
                    begin
                        if (hops_reg < ram_rd_data.hops)
                        begin
                            ram_wr_en       = 1'b1;
                            out_status_next = ST_REPLACED;
                        end
                        else
                        begin
                            out_status_next = ST_KEPT;
                        end
                    end
                    else if (km_stat.has_free)
                    begin
                        ram_wr_en       = 1'b1;
                        ram_wr_addr     = km_stat.free_idx;
                        km_cmd.wr       = 1'b1;
                        km_cmd.idx      = km_stat.free_idx;
                        out_status_next = ST_INSERTED;
                    end
                    else
                    begin
                        out_status_next = ST_FULL;
                    end
                end
            end

            // one read issued per cycle, check one entry per cycle
            S_AGE:
            begin
                if (issue_reg != ISSUE_W'(TABLE_ENTRIES))
                begin
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = issue_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[IDX_W-1:0];
                    issue_next    = issue_reg + ISSUE_W'(1);
                end
                if (pend_reg && valid[pend_idx_reg] && stale)
                begin
                    km_cmd.clr = 1'b1;
                    km_cmd.idx = pend_idx_reg;
                    if (removed_reg != {COUNT_W{1'b1}})
                    begin
                        removed_next = removed_reg + COUNT_W'(1);
                    end
                end
                if (sweep_done && out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_AGED;
                    out_nh_next     = '0;
                    out_hops_next   = '0;
                    out_seq_next    = '0;
                    out_cnt_next    = removed_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            removed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            removed_reg   <= removed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        dest_reg       <= dest_next;
        nh_reg         <= nh_next;
        hops_reg       <= hops_next;
        seq_reg        <= seq_next;
        now_reg        <= now_next;
        pend_idx_reg   <= pend_idx_next;
        out_status_reg <= out_status_next;
        out_nh_reg     <= out_nh_next;
        out_hops_reg   <= out_hops_next;
        out_seq_reg    <= out_seq_next;
        out_cnt_reg    <= out_cnt_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.status         = out_status_reg;
    assign out_ch.route_next_hop = out_nh_reg;
    assign out_ch.route_hops     = out_hops_reg;
    assign out_ch.route_seq      = out_seq_reg;
    assign out_ch.removed_count  = out_cnt_reg;

endmodule

// ===== hw/rtl/rtae_cfg.sv =====
// ============================================================================
// rtae_cfg
// APB register block holding the aging timeout.
// ============================================================================
module rtae_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rtae_pkg::PADDR_W-1:0]   paddr,
    input  logic [rtae_pkg::PDATA_W-1:0]   pwdata,
    output logic [rtae_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output logic [rtae_pkg::TIMEOUT_W-1:0] timeout
);
    import rtae_pkg::*;

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [TIMEOUT_W-1:0] timeout_next;
    logic                 sel_timeout;

    // register index is paddr[2]; low bits are the byte offset
    assign sel_timeout = (paddr[2] == REG_TIMEOUT);

    always_comb
    begin
        timeout_next = timeout_reg;
        if (psel && penable && pwrite && sel_timeout)
        begin
            timeout_next = pwdata[TIMEOUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    // read back; unmapped addresses read zero
    assign prdata  = sel_timeout ? PDATA_W'(timeout_reg) : '0;
    assign pready  = 1'b1;
    assign timeout = timeout_reg;

endmodule

// ===== hw/rtl/rtae_entry_ram.sv =====
// ============================================================================
// rtae_entry_ram
// Route payload memory: one write port, one registered read port.
// ============================================================================
module rtae_entry_ram (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [rtae_pkg::IDX_W-1:0] wr_addr,
    input  rtae_pkg::entry_t           wr_data,
    input  logic                       rd_en,
    input  logic [rtae_pkg::IDX_W-1:0] rd_addr,
    output rtae_pkg::entry_t           rd_data
);
    import rtae_pkg::*;

    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/rtae_key_match.sv =====
// ============================================================================
// rtae_key_match
// Destination keys and valid bits in flops; registered parallel compare
// followed by priority encoding of the hit and the lowest free slot.
// ============================================================================
module rtae_key_match (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rtae_pkg::km_cmd_t                  cmd,
    output rtae_pkg::km_stat_t                 stat,
    output logic [rtae_pkg::TABLE_ENTRIES-1:0] valid
);
    import rtae_pkg::*;

    logic [KEY_W-1:0]         key_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic [TABLE_ENTRIES-1:0] match_reg;
    logic [TABLE_ENTRIES-1:0] match_next;
    logic [TABLE_ENTRIES-1:0] free_reg;
    logic [TABLE_ENTRIES-1:0] free_next;

    // valid bit updates
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.wr)
        begin
            valid_next[cmd.idx] = 1'b1;
        end
        if (cmd.clr)
        begin
            valid_next[cmd.idx] = 1'b0;
        end
    end

    // compare every valid key against the request key
    always_comb
    begin
        match_next = match_reg;
        free_next  = free_reg;
        if (cmd.cmp)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                match_next[i] = valid_reg[i] && (key_reg[i] == cmd.key);
            end
            free_next = ~valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            match_reg <= '0;
            free_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
            free_reg  <= free_next;
        end
    end

    // key storage, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            key_reg[cmd.idx] <= cmd.key;
        end
    end

    // lowest-index hit and lowest-index free slot
    always_comb
    begin
        stat = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                stat.hit     = 1'b1;
                stat.hit_idx = IDX_W'(i);
            end
            if (free_reg[i])
            begin
                stat.has_free = 1'b1;
                stat.free_idx = IDX_W'(i);
            end
        end
    end

    assign valid = valid_reg;

endmodule
